// ===== rtl/vwfg_pkg.sv =====
// Shared types, constants and codes for the video warm-up frame gate.
`timescale 1ns / 1ps

package vwfg_pkg;

  // Saturating sample counters
  localparam int COUNT_BITS = 20;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Flat percentage divider: quotient never exceeds 100, so 7 bits
  localparam int QUOT_W    = 7;
  localparam int DIV_STEPS = QUOT_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int DIVD_W    = COUNT_BITS + QUOT_W;
  localparam logic [QUOT_W-1:0] PERCENT_FULL = 7'd100;

  // FNV-1a constants
  localparam logic [31:0] HASH_SEED = 32'd2166136261;
  localparam logic [31:0] HASH_MUL  = 32'd16777619;

  // Minimum valid frame dimension
  localparam logic [13:0] MIN_DIM = 14'd16;

  // Port widths
  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Input item kinds (code 3 is ignored)
  localparam logic [1:0] KIND_RESTART   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE    = 2'd1;
  localparam logic [1:0] KIND_FRAME_END = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_FRAMES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_MS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_RUN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAT_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING_MS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAXED_FLAT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HARD_DEADLINE = 3'd6;

  // Configuration reset values
  localparam logic [7:0]  RST_FLOOR_FRAMES  = 8'd12;
  localparam logic [15:0] RST_FLOOR_MS      = 16'd800;
  localparam logic [7:0]  RST_STABLE_RUN    = 8'd8;
  localparam logic [6:0]  RST_FLAT_LIMIT    = 7'd10;
  localparam logic [15:0] RST_CEILING_MS    = 16'd10000;
  localparam logic [6:0]  RST_RELAXED_FLAT  = 7'd85;
  localparam logic [15:0] RST_HARD_DEADLINE = 16'd15000;

  // Result reasons
  typedef enum logic [2:0] {
    REASON_COUNT_HOLD  = 3'd0,
    REASON_FLOOR_HOLD  = 3'd1,
    REASON_UNSTABLE    = 3'd2,
    REASON_STABLE      = 3'd3,
    REASON_DEADLINE    = 3'd4,
    REASON_CEILING     = 3'd5,
    REASON_PASSTHROUGH = 3'd6
  } reason_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DIVIDE = 2'd1,
    ST_DECIDE = 2'd2
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take_sample;
    logic take_restart;
    logic take_frame;
    logic div_step;
    logic decide;
  } vwfg_cmd_t;

endpackage

// ===== rtl/vwfg_ctrl.sv =====
// Controller state machine: input acceptance, divider sequencing, result register valid.
`timescale 1ns / 1ps

module vwfg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic [1:0]          s_kind,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output vwfg_pkg::vwfg_cmd_t cmd
);
  import vwfg_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step_cnt;
  logic              out_valid;
  logic              out_free;

  assign out_free = !out_valid || m_tready;
  assign m_tvalid = out_valid;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && s_kind == KIND_FRAME_END) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (step_cnt == '0) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    s_tready         = (state == ST_IDLE);
    cmd.take_sample  = (state == ST_IDLE) && s_tvalid && s_kind == KIND_SAMPLE;
    cmd.take_restart = (state == ST_IDLE) && s_tvalid && s_kind == KIND_RESTART;
    cmd.take_frame   = (state == ST_IDLE) && s_tvalid && s_kind == KIND_FRAME_END;
    cmd.div_step     = (state == ST_DIVIDE);
    cmd.decide       = (state == ST_DECIDE) && out_free;
  end

  // State, step counter, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.take_frame) begin
        step_cnt <= STEP_W'(DIV_STEPS - 1);
      end else if (cmd.div_step && step_cnt != '0) begin
        step_cnt <= step_cnt - 1'b1;
      end
      if (cmd.decide) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/vwfg_datapath.sv =====
// Datapath: config registers, sample accumulators, flat divider, warm-up decision.
`timescale 1ns / 1ps

module vwfg_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  vwfg_pkg::vwfg_cmd_t               cmd,
  input  logic [vwfg_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  logic                              new_source,
  input  logic                              cfg_we,
  input  logic [vwfg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vwfg_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic [vwfg_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import vwfg_pkg::*;

  // Input fields
  logic [7:0]  sample_luma;
  logic [7:0]  neighbor_luma;
  logic [13:0] frame_width;
  logic [13:0] frame_height;
  logic [31:0] now_ms;

  assign sample_luma   = s_tdata[7:0];
  assign neighbor_luma = s_tdata[15:8];
  assign frame_width   = s_tdata[29:16];
  assign frame_height  = s_tdata[43:30];
  assign now_ms        = s_tdata[75:44];

  // Configuration
  logic [7:0]  floor_frames;
  logic [15:0] floor_ms;
  logic [7:0]  stable_run_length;
  logic [6:0]  flat_limit_percent;
  logic [15:0] ceiling_ms;
  logic [6:0]  relaxed_flat_pct;
  logic [15:0] hard_deadline_ms;

  // Warm-up state
  logic        shown_flag;
  logic        first_seen_flag;
  logic [7:0]  frames_remaining;
  logic [31:0] start_time_ms;
  logic [7:0]  run_count;
  logic [31:0] previous_hash;
  logic        previous_hash_valid;

  // Accumulators
  logic [31:0]           hash_accumulator;
  logic [COUNT_BITS-1:0] flat_count;
  logic [COUNT_BITS-1:0] sample_count;

  // Frame held for evaluation
  logic              frame_invalid;
  logic [31:0]       frame_hash;
  logic [31:0]       frame_now;
  logic [DIVD_W-1:0] div_rem;
  logic [DIVD_W-1:0] div_shift;
  logic [QUOT_W-1:0] div_quot;

  // Decision outputs
  logic        shown_flag_next;
  logic        first_seen_flag_next;
  logic [7:0]  frames_remaining_next;
  logic [31:0] start_time_ms_next;
  logic [7:0]  run_count_next;
  logic [31:0] previous_hash_next;
  logic        previous_hash_valid_next;
  logic        res_deliver;
  reason_t     res_reason;
  logic [6:0]  res_flat;
  logic        res_first;

  logic [6:0]  flat_val;
  logic [31:0] start_eff;
  logic [31:0] waited;
  logic        clean;
  logic        moving;
  logic [7:0]  run_upd;
  logic        frame_bad;

  assign frame_bad = (frame_width < MIN_DIM) || (frame_height < MIN_DIM) || (sample_count == '0);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      floor_frames         <= RST_FLOOR_FRAMES;
      floor_ms             <= RST_FLOOR_MS;
      stable_run_length    <= RST_STABLE_RUN;
      flat_limit_percent   <= RST_FLAT_LIMIT;
      ceiling_ms           <= RST_CEILING_MS;
      relaxed_flat_pct     <= RST_RELAXED_FLAT;
      hard_deadline_ms     <= RST_HARD_DEADLINE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FLOOR_FRAMES:  floor_frames         <= cfg_data[7:0];
        CFG_FLOOR_MS:      floor_ms             <= cfg_data;
        CFG_STABLE_RUN:    stable_run_length    <= cfg_data[7:0];
        CFG_FLAT_LIMIT:    flat_limit_percent   <= cfg_data[6:0];
        CFG_CEILING_MS:    ceiling_ms           <= cfg_data;
        CFG_RELAXED_FLAT:  relaxed_flat_pct     <= cfg_data[6:0];
        CFG_HARD_DEADLINE: hard_deadline_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sample accumulators: cleared by restart and frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_accumulator <= HASH_SEED;
      flat_count       <= '0;
      sample_count     <= '0;
    end else if (cmd.take_restart || cmd.take_frame) begin
      hash_accumulator <= HASH_SEED;
      flat_count       <= '0;
      sample_count     <= '0;
    end else if (cmd.take_sample) begin
      hash_accumulator <= (hash_accumulator ^ {24'd0, sample_luma}) * HASH_MUL;
      if (sample_count != COUNT_MAX) begin
        sample_count <= sample_count + 1'b1;
        if (sample_luma == neighbor_luma) flat_count <= flat_count + 1'b1;
      end
    end
  end

  // Frame capture and restoring divider, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.take_frame) begin
      frame_invalid <= frame_bad;
      frame_hash    <= frame_bad ? 32'd0 : hash_accumulator;
      frame_now     <= now_ms;
      div_rem       <= DIVD_W'(flat_count) * DIVD_W'(PERCENT_FULL);
      div_shift     <= {1'b0, sample_count, {(QUOT_W-1){1'b0}}};
      div_quot      <= '0;
    end else if (cmd.div_step) begin
      if (div_rem >= div_shift) begin
        div_rem  <= div_rem - div_shift;
        div_quot <= {div_quot[QUOT_W-2:0], 1'b1};
      end else begin
        div_quot <= {div_quot[QUOT_W-2:0], 1'b0};
      end
      div_shift <= div_shift >> 1;
    end
  end

  // Warm-up decision for the held frame
  always_comb begin
    flat_val  = frame_invalid ? PERCENT_FULL : div_quot;
    start_eff = first_seen_flag ? start_time_ms : frame_now;
    waited    = frame_now - start_eff;
    clean     = flat_val < flat_limit_percent;
    moving    = previous_hash_valid && (frame_hash != previous_hash);
    if (clean && moving) begin
      run_upd = (run_count == 8'hFF) ? run_count : run_count + 8'd1;
    end else begin
      run_upd = 8'd0;
    end

    shown_flag_next          = shown_flag;
    first_seen_flag_next     = first_seen_flag;
    frames_remaining_next    = frames_remaining;
    start_time_ms_next       = start_time_ms;
    run_count_next           = run_count;
    previous_hash_next       = previous_hash;
    previous_hash_valid_next = previous_hash_valid;
    res_deliver              = 1'b1;
    res_reason               = REASON_PASSTHROUGH;
    res_flat                 = 7'd0;
    res_first                = 1'b0;

    if (!shown_flag) begin
      first_seen_flag_next = 1'b1;
      start_time_ms_next   = start_eff;
      res_deliver          = 1'b0;
      priority if (frames_remaining != 8'd0) begin
        frames_remaining_next = frames_remaining - 8'd1;
        res_reason            = REASON_COUNT_HOLD;
      end else if (waited < {16'd0, floor_ms}) begin
        res_reason = REASON_FLOOR_HOLD;
      end else begin
        previous_hash_next       = frame_hash;
        previous_hash_valid_next = 1'b1;
        run_count_next           = run_upd;
        res_flat                 = flat_val;
        priority if (run_upd >= stable_run_length) begin
          res_reason = REASON_STABLE;
        end else if (waited >= {16'd0, hard_deadline_ms}) begin
          res_reason = REASON_DEADLINE;
        end else if (waited >= {16'd0, ceiling_ms} && flat_val < relaxed_flat_pct) begin
          res_reason = REASON_CEILING;
        end else begin
          res_reason = REASON_UNSTABLE;
        end
        if (res_reason != REASON_UNSTABLE) begin
          shown_flag_next = 1'b1;
          res_deliver     = 1'b1;
          res_first       = 1'b1;
        end
      end
    end
  end

  // Warm-up state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      shown_flag          <= 1'b0;
      first_seen_flag     <= 1'b0;
      frames_remaining    <= RST_FLOOR_FRAMES;
      start_time_ms       <= '0;
      run_count           <= '0;
      previous_hash       <= '0;
      previous_hash_valid <= 1'b0;
    end else if (cmd.take_restart) begin
      if (new_source) shown_flag <= 1'b0;
      if (new_source || !shown_flag) begin
        first_seen_flag     <= 1'b0;
        frames_remaining    <= floor_frames;
        run_count           <= '0;
        previous_hash_valid <= 1'b0;
      end
    end else if (cmd.decide) begin
      shown_flag          <= shown_flag_next;
      first_seen_flag     <= first_seen_flag_next;
      frames_remaining    <= frames_remaining_next;
      start_time_ms       <= start_time_ms_next;
      run_count           <= run_count_next;
      previous_hash       <= previous_hash_next;
      previous_hash_valid <= previous_hash_valid_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      m_tdata <= {4'd0, res_first, res_flat, res_reason, res_deliver};
    end
  end

endmodule

// ===== rtl/video_warmup_frame_gate.sv =====
// Top level of the video warm-up frame gate.
// Restart and grid sample items: one transfer per cycle while the controller is idle, no result.
// Frame end: the frame is captured, the bit-serial flat percentage divider runs its 7 steps,
//   then the decide state registers the result; no input is taken until that decision is made.
// A waiting result does not block input transfers; only the decision of a frame end waits for it.
// Synchronous active-high reset loads register defaults and resets all warm-up state.
`timescale 1ns / 1ps

module video_warmup_frame_gate (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // sample_luma[7:0], neighbor_luma[15:8], frame_width[29:16], frame_height[43:30],
  // now_ms[75:44], zero fill
  input  logic [vwfg_pkg::IN_TDATA_W-1:0]   s_tdata,
  // kind[1:0], new_source[2]
  input  logic [vwfg_pkg::IN_TUSER_W-1:0]   s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // deliver[0], reason[3:1], flat_pct[10:4], first_release[11], zero fill
  output logic [vwfg_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                              cfg_we,
  input  logic [vwfg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vwfg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import vwfg_pkg::*;

  vwfg_cmd_t cmd;

  vwfg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_kind   (s_tuser[1:0]),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  vwfg_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .s_tdata    (s_tdata),
    .new_source (s_tuser[2]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .m_tdata    (m_tdata)
  );

endmodule

// ===== rtl/vwfg_checker.sv =====
// Port-level checker for the warm-up frame gate, bound to the top level.
`timescale 1ns / 1ps

module vwfg_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [vwfg_pkg::IN_TUSER_W-1:0]   s_tuser,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [vwfg_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import vwfg_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A frame end transfer blocks further input while it is evaluated
  a_frame_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[1:0] == KIND_FRAME_END |=> !s_tready)
    else $error("input taken during frame evaluation");

  // Holds and unstable frames are dropped, all other reasons deliver
  a_deliver_reason: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] != REASON_COUNT_HOLD &&
                                 m_tdata[3:1] != REASON_FLOOR_HOLD &&
                                 m_tdata[3:1] != REASON_UNSTABLE)))
    else $error("deliver does not match reason");

  // First release only comes from an evaluated release
  a_first_release: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[11] |-> m_tdata[0] && m_tdata[3:1] != REASON_PASSTHROUGH)
    else $error("first release on a passthrough or dropped frame");

  // Flat percentage stays in range
  a_flat_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[10:4] <= PERCENT_FULL)
    else $error("flat percentage above 100");

endmodule

bind video_warmup_frame_gate vwfg_checker u_vwfg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== bench/vwfg_gate_checker.sv =====
// Scoreboard for the warm-up frame gate: tracks transfers, predicts decisions, compares.
`timescale 1ns / 1ps

module vwfg_gate_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  // sample_luma[7:0], neighbor_luma[15:8], frame_width[29:16], frame_height[43:30],
  // now_ms[75:44], zero fill
  input  logic [vwfg_pkg::IN_TDATA_W-1:0]   s_tdata,
  // kind[1:0], new_source[2]
  input  logic [vwfg_pkg::IN_TUSER_W-1:0]   s_tuser,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  // deliver[0], reason[3:1], flat_pct[10:4], first_release[11], zero fill
  input  logic [vwfg_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                              cfg_we,
  input  logic [vwfg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vwfg_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int unsigned                       fail_count,
  output int unsigned                       pending,
  output int unsigned                       decisions,
  output int unsigned                       releases
);
  import vwfg_pkg::*;

  typedef struct packed {
    logic           deliver;
    reason_t        reason;
    logic [6:0]     flat_pct;
    logic           first_rel;
  } verdict_t;

  // Mirrored settings
  logic [7:0]  hold_frames_cfg;
  logic [15:0] hold_ms_cfg;
  logic [7:0]  run_needed_cfg;
  logic [6:0]  clean_pct_cfg;
  logic [15:0] relax_ms_cfg;
  logic [6:0]  relax_pct_cfg;
  logic [15:0] deadline_ms_cfg;

  // Warm-up state and per-frame statistics
  logic                  shown;
  logic                  seen_first;
  logic [7:0]            frames_left;
  logic [31:0]           t_start;
  logic [7:0]            run_len;
  logic [31:0]           last_sig;
  logic                  last_sig_ok;
  logic [31:0]           sig_acc;
  logic [COUNT_BITS-1:0] flat_cnt;
  logic [COUNT_BITS-1:0] samp_cnt;

  verdict_t verdict_q[$];

  function automatic void clear_frame_stats();
    sig_acc  = HASH_SEED;
    flat_cnt = '0;
    samp_cnt = '0;
  endfunction

  function automatic void rearm_warmup();
    seen_first  = 1'b0;
    frames_left = hold_frames_cfg;
    run_len     = '0;
    last_sig_ok = 1'b0;
  endfunction

  function automatic void reset_gate_model();
    hold_frames_cfg = RST_FLOOR_FRAMES;
    hold_ms_cfg     = RST_FLOOR_MS;
    run_needed_cfg  = RST_STABLE_RUN;
    clean_pct_cfg   = RST_FLAT_LIMIT;
    relax_ms_cfg    = RST_CEILING_MS;
    relax_pct_cfg   = RST_RELAXED_FLAT;
    deadline_ms_cfg = RST_HARD_DEADLINE;
    shown    = 1'b0;
    t_start  = '0;
    last_sig = '0;
    rearm_warmup();
    clear_frame_stats();
  endfunction

  function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_FLOOR_FRAMES:  hold_frames_cfg = val[7:0];
      CFG_FLOOR_MS:      hold_ms_cfg     = val;
      CFG_STABLE_RUN:    run_needed_cfg  = val[7:0];
      CFG_FLAT_LIMIT:    clean_pct_cfg   = val[6:0];
      CFG_CEILING_MS:    relax_ms_cfg    = val;
      CFG_RELAXED_FLAT:  relax_pct_cfg   = val[6:0];
      CFG_HARD_DEADLINE: deadline_ms_cfg = val;
      default: ;
    endcase
  endfunction

  // Equal-pair count saturates together with the sample count; hash always folds
  function automatic void fold_sample(input logic [7:0] luma, input logic [7:0] nbr);
    if (samp_cnt < COUNT_MAX) begin
      samp_cnt = samp_cnt + 1'b1;
      if (luma == nbr)
        flat_cnt = flat_cnt + 1'b1;
    end
    sig_acc = (sig_acc ^ {24'd0, luma}) * HASH_MUL;
  endfunction

  // Decision for one frame end; updates the warm-up state
  function automatic verdict_t judge_frame(input logic [13:0] w, input logic [13:0] h,
                                           input logic [31:0] now);
    verdict_t    v;
    logic [6:0]  pct;
    logic [31:0] sig;
    logic [31:0] waited;
    logic [63:0] scaled;
    logic        clean;
    logic        moving;
    v = '{1'b1, REASON_PASSTHROUGH, 7'd0, 1'b0};
    if (w < MIN_DIM || h < MIN_DIM || samp_cnt == 0) begin
      pct = PERCENT_FULL;
      sig = '0;
    end else begin
      scaled = 64'(flat_cnt) * 64'd100;
      pct    = 7'(scaled / 64'(samp_cnt));
      sig    = sig_acc;
    end
    clear_frame_stats();
    if (shown)
      return v;

    if (!seen_first) begin
      seen_first = 1'b1;
      t_start    = now;
    end
    waited    = now - t_start;
    v.deliver = 1'b0;
    if (frames_left != 0) begin
      frames_left = frames_left - 1'b1;
      v.reason    = REASON_COUNT_HOLD;
      return v;
    end
    if (waited < hold_ms_cfg) begin
      v.reason = REASON_FLOOR_HOLD;
      return v;
    end

    // Stability run: clean and changed since the last evaluated frame
    clean       = pct < clean_pct_cfg;
    moving      = last_sig_ok && (sig != last_sig);
    last_sig    = sig;
    last_sig_ok = 1'b1;
    if (clean && moving) begin
      if (run_len != 8'hFF)
        run_len = run_len + 1'b1;
    end else begin
      run_len = '0;
    end

    v.flat_pct = pct;
    if (run_len >= run_needed_cfg)
      v.reason = REASON_STABLE;
    else if (waited >= deadline_ms_cfg)
      v.reason = REASON_DEADLINE;
    else if (waited >= relax_ms_cfg && pct < relax_pct_cfg)
      v.reason = REASON_CEILING;
    else
      v.reason = REASON_UNSTABLE;

    if (v.reason != REASON_UNSTABLE) begin
      shown       = 1'b1;
      v.deliver   = 1'b1;
      v.first_rel = 1'b1;
    end
    return v;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t   want;
    verdict_t   got;
    logic [1:0] kind;
    if (rst) begin
      reset_gate_model();
      verdict_q.delete();
      fail_count = 0;
      decisions  = 0;
      releases   = 0;
    end else begin
      // Result side first: a same-edge input cannot have produced this result
      if (m_tvalid && m_tready) begin
        got.deliver   = m_tdata[0];
        got.reason    = reason_t'(m_tdata[3:1]);
        got.flat_pct  = m_tdata[10:4];
        got.first_rel = m_tdata[11];
        if (verdict_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transfer: deliver=%0d reason=%0d flat=%0d first=%0d",
                     got.deliver, got.reason, got.flat_pct, got.first_rel);
        end else begin
          want = verdict_q.pop_front();
          decisions++;
          if (want.first_rel)
            releases++;
          if (got.deliver !== want.deliver || got.reason !== want.reason ||
              got.flat_pct !== want.flat_pct || got.first_rel !== want.first_rel) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("decision %0d mismatch: expected deliver=%0d reason=%0d flat=%0d first=%0d",
                       decisions, want.deliver, want.reason, want.flat_pct, want.first_rel);
              $display("  got deliver=%0d reason=%0d flat=%0d first=%0d",
                       got.deliver, got.reason, got.flat_pct, got.first_rel);
            end
          end
        end
      end

      if (cfg_we)
        apply_setting(cfg_index, cfg_data);

      if (s_tvalid && s_tready) begin
        kind = s_tuser[1:0];
        case (kind)
          KIND_RESTART: begin
            if (s_tuser[2])
              shown = 1'b0;
            if (!shown)
              rearm_warmup();
            clear_frame_stats();
          end
          KIND_SAMPLE:    fold_sample(s_tdata[7:0], s_tdata[15:8]);
          KIND_FRAME_END: verdict_q.push_back(judge_frame(s_tdata[29:16], s_tdata[43:30],
                                                          s_tdata[75:44]));
          default: ;
        endcase
      end
    end
    pending = verdict_q.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Stimulus, flow control and verdict for the video warm-up frame gate.
`timescale 1ns / 1ps

module testbench;
  import vwfg_pkg::*;

  localparam int unsigned ITEM_TARGET = 1150;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  // How a settings phase picks register values
  localparam int SET_LOWEST  = 0;
  localparam int SET_HIGHEST = 1;
  localparam int SET_RANDOM  = 2;

  typedef enum int {
    FS_MOVING, FS_FLAT, FS_MIXED, FS_REPEAT, FS_INVALID, FS_EMPTY
  } frame_style_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_TDATA_W-1:0]    s_tdata = '0;
  logic [IN_TUSER_W-1:0]    s_tuser = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]   m_tdata;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned decisions;
  int unsigned releases;

  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned cfg_writes = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  // Last frame's samples, kept so a frame can be replayed with an identical hash
  logic [7:0]  prev_luma [64];
  logic [7:0]  prev_nbr [64];
  int unsigned prev_len = 0;

  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  video_warmup_frame_gate dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  vwfg_gate_checker gate_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .decisions  (decisions),
    .releases   (releases)
  );

  // Result receiver: random stalls, calm stretches and one long hold-off
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  // One input transfer; called and returning at a rising edge
  task automatic send_item(input logic [1:0] kind, input logic new_src,
                           input logic [7:0] luma, input logic [7:0] nbr,
                           input logic [13:0] w, input logic [13:0] h,
                           input logic [31:0] now);
    int unsigned gap;
    if (!calm && $urandom_range(0, 99) < 4) begin
      gap = $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, now, h, w, nbr, luma};
    s_tuser  <= {new_src, kind};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    if (kind != KIND_UNUSED)
      items_sent++;
  endtask

  // Unused fields carry junk; the block must ignore them
  task automatic send_restart(input logic new_src);
    send_item(KIND_RESTART, new_src, 8'($urandom), 8'($urandom), 14'($urandom),
              14'($urandom), $urandom);
  endtask

  task automatic send_sample(input logic [7:0] luma, input logic [7:0] nbr);
    send_item(KIND_SAMPLE, 1'($urandom), luma, nbr, 14'($urandom), 14'($urandom), $urandom);
  endtask

  task automatic send_frame_end(input logic [13:0] w, input logic [13:0] h,
                                input logic [31:0] now);
    send_item(KIND_FRAME_END, 1'($urandom), 8'($urandom), 8'($urandom), w, h, now);
  endtask

  // Drop valid, let all decisions drain, then give the divider time to go idle
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_writes++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_setting(input int mode, input int unsigned top,
                                                          input int unsigned lo,
                                                          input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (mode == SET_LOWEST || (mode == SET_RANDOM && r < 12))
      return '0;
    if (mode == SET_HIGHEST || r < 24)
      return CFG_DATA_W'(top);
    return CFG_DATA_W'($urandom_range(lo, hi));
  endfunction

  task automatic program_gate(input int mode);
    write_reg(CFG_FLOOR_FRAMES,  pick_setting(mode, 255, 0, 10));
    write_reg(CFG_FLOOR_MS,      pick_setting(mode, 65535, 0, 3000));
    write_reg(CFG_STABLE_RUN,    pick_setting(mode, 255, 0, 10));
    write_reg(CFG_FLAT_LIMIT,    pick_setting(mode, 127, 1, 100));
    write_reg(CFG_CEILING_MS,    pick_setting(mode, 65535, 0, 20000));
    write_reg(CFG_RELAXED_FLAT,  pick_setting(mode, 127, 0, 100));
    write_reg(CFG_HARD_DEADLINE, pick_setting(mode, 65535, 0, 40000));
    cfg_we <= 1'b0;
  endtask

  function automatic frame_style_t pick_style();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return FS_MOVING;
    if (r < 72) return FS_FLAT;
    if (r < 79) return FS_MIXED;
    if (r < 86) return FS_REPEAT;
    if (r < 93) return FS_INVALID;
    return FS_EMPTY;
  endfunction

  // Samples of one frame followed by its frame end
  task automatic send_frame(input frame_style_t style, input logic [31:0] now);
    int unsigned count;
    logic [7:0]  luma;
    logic [7:0]  nbr;
    logic [13:0] w;
    logic [13:0] h;
    if (style == FS_EMPTY)
      count = 0;
    else if (style == FS_REPEAT)
      count = prev_len;
    else if ($urandom_range(0, 19) == 0)
      count = $urandom_range(7, 40);
    else
      count = $urandom_range(1, 6);

    for (int i = 0; i < count; i++) begin
      if (style == FS_REPEAT) begin
        luma = prev_luma[i];
        nbr  = prev_nbr[i];
      end else begin
        luma = 8'($urandom);
        case (style)
          FS_FLAT:  nbr = luma;
          FS_MIXED: nbr = $urandom_range(0, 1) ? luma : 8'($urandom);
          default:  nbr = ($urandom_range(0, 31) == 0) ? luma
                                                       : luma ^ 8'($urandom_range(1, 255));
        endcase
        prev_luma[i] = luma;
        prev_nbr[i]  = nbr;
      end
      send_sample(luma, nbr);
    end
    prev_len = count;

    w = 14'($urandom_range(16, 16383));
    h = 14'($urandom_range(16, 16383));
    if (style == FS_INVALID) begin
      case ($urandom_range(0, 2))
        0:       w = 14'($urandom_range(0, 15));
        1:       h = 14'($urandom_range(0, 15));
        default: begin
          w = 14'($urandom_range(0, 15));
          h = 14'($urandom_range(0, 15));
        end
      endcase
    end else if ($urandom_range(0, 7) == 0) begin
      w = $urandom_range(0, 1) ? 14'd16 : 14'h3FFF;
      h = $urandom_range(0, 1) ? 14'd16 : 14'h3FFF;
    end
    send_frame_end(w, h, now);
  endtask

  initial begin : stimulus
    int          phase;
    int unsigned frames;
    int unsigned tick_max;
    int unsigned r;
    logic [31:0] clock_ms;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: short warm-up, time wrap, flat and invalid frames, release, restarts
    write_reg(CFG_FLOOR_FRAMES, 16'd1);
    write_reg(CFG_FLOOR_MS, 16'd0);
    write_reg(CFG_STABLE_RUN, 16'd2);
    write_reg(CFG_FLAT_LIMIT, 16'd50);
    write_reg(CFG_CEILING_MS, 16'hFFFF);
    write_reg(CFG_RELAXED_FLAT, 16'd0);
    write_reg(CFG_HARD_DEADLINE, 16'hFFFF);
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;

    send_item(KIND_UNUSED, 1'b1, 8'hFF, 8'hFF, 14'h3FFF, 14'h3FFF, 32'hFFFF_FFFF);
    send_frame_end(14'h3FFF, 14'h3FFF, 32'hFFFF_FFF0);
    send_sample(8'd0, 8'd0);
    send_sample(8'd255, 8'd255);
    send_sample(8'd255, 8'd0);
    send_sample(8'd0, 8'd255);
    send_frame_end(14'd16, 14'd16, 32'hFFFF_FFFF);
    send_sample(8'd17, 8'd200);
    send_frame_end(14'd15, 14'd100, 32'd0);
    send_sample(8'd1, 8'd2);
    send_frame_end(14'd100, 14'd15, 32'd3);
    send_frame_end(14'h3FFF, 14'd16, 32'd4);
    send_sample(8'd9, 8'd3);
    send_sample(8'd200, 8'd7);
    send_frame_end(14'd640, 14'd480, 32'd5);
    send_sample(8'd33, 8'd34);
    send_frame_end(14'd640, 14'd480, 32'd6);
    send_sample(8'd5, 8'd5);
    send_frame_end(14'd640, 14'd480, 32'd7);
    send_restart(1'b0);
    send_frame_end(14'd640, 14'd480, 32'd8);
    send_restart(1'b1);
    send_frame_end(14'd640, 14'd480, 32'd9);
    send_frame_end(14'd640, 14'd480, 32'd10);

    // Random phases: each with its own settings, a fresh source and a run of frames
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      program_gate(phase == 0 ? SET_LOWEST : (phase == 1 ? SET_HIGHEST : SET_RANDOM));
      calm = (phase == 2);
      if (phase == 3)
        hold_req = 1'b1;
      send_restart(1'b1);
      case ($urandom_range(0, 3))
        0:       tick_max = 30;
        1:       tick_max = 400;
        2:       tick_max = 2500;
        default: tick_max = 9000;
      endcase
      clock_ms = $urandom;
      frames = (phase == 1) ? 20 : $urandom_range(12, 40);
      for (int f = 0; f < frames && items_sent < ITEM_TARGET; f++) begin
        // Occasional restarts, ignored items and time jumps between frames
        r = $urandom_range(0, 99);
        if (r < 3)
          send_restart(1'b0);
        else if (r < 5)
          send_restart(1'b1);
        else if (r < 7)
          send_item(KIND_UNUSED, 1'($urandom), 8'($urandom), 8'($urandom), 14'($urandom),
                    14'($urandom), $urandom);
        else if (r < 9)
          clock_ms = $urandom;
        clock_ms = clock_ms + $urandom_range(0, tick_max);
        send_frame(pick_style(), clock_ms);
      end
      phase++;
    end

    calm = 1'b0;
    settle();
    $display("Covered %0d input transfers and %0d register writes over %0d settings phases;",
             items_sent, cfg_writes, phase + 1);
    $display("%0d frame decisions checked, %0d of them first releases.", decisions, releases);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d decisions still outstanding", cycle_count, pending);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
